// ----- hw/rtl/hrc_pkg.sv -----
// shared types, constants and a hash helper for the hashed result cache
`timescale 1ns / 1ps
`default_nettype none

package hrc_pkg;

  localparam logic [63:0] HASH_BASIS     = 64'd14695981039346656037;
  // prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply
  localparam int unsigned HASH_PRIME_SHIFT = 40;
  localparam logic [8:0]  HASH_PRIME_LOW = 9'h1b3;
  localparam logic [63:0] KEY_IGNORE_MASK = 64'h4000_0000_0000_0000;
  localparam int unsigned DATA_SLOT_SHIFT = 34;
  localparam int unsigned HALF_SHIFT      = 32;
  localparam logic [1:0]  HASH_LAST_ROUND = 2'd2;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_STORE  = 1'b1
  } hrc_op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } hrc_front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_IDX,
    B_DATA,
    B_RESP
  } hrc_back_state_t;

  // classified command handed from the front to the back
  typedef struct packed {
    hrc_op_t     op;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] store_value;
    logic [63:0] hash;
  } hrc_cmd_t;

  typedef struct packed {
    logic clearing;
  } hrc_back_status_t;

  // one hash round: multiply by the prime, modulo 2^64
  function automatic logic [63:0] hrc_mix(input logic [63:0] x);
    logic [63:0] low_part;
    low_part = x * {55'd0, HASH_PRIME_LOW};
    return (x << HASH_PRIME_SHIFT) + low_part;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrc_if.sv -----
// request and response channel interfaces of the hashed result cache
`timescale 1ns / 1ps
`default_nettype none

interface hrc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] key_a;
  logic [63:0] key_b;
  logic [63:0] key_c;
  logic [63:0] store_value;

  modport source (
    output valid, operation, key_a, key_b, key_c, store_value,
    input  ready
  );
  modport sink (
    input  valid, operation, key_a, key_b, key_c, store_value,
    output ready
  );
endinterface

interface hrc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] found_value;

  modport source (
    output valid, hit, found_value,
    input  ready
  );
  modport sink (
    input  valid, hit, found_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/hrc_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module hrc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrc_front.sv -----
// front end: accepts request beats and hashes the key over three rounds
`timescale 1ns / 1ps
`default_nettype none

module hrc_front import hrc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  hrc_req_if.sink               req,
  input  wire hrc_back_status_t status,
  output logic                  push_valid,
  output hrc_cmd_t              push_cmd,
  input  wire logic             push_ready
);

  hrc_front_state_t state, state_next;
  logic [1:0]       round;
  hrc_cmd_t         cmd;
  logic [63:0]      masked_a;
  logic [63:0]      round_word;

  assign masked_a = req.key_a & ~KEY_IGNORE_MASK;

  always_comb begin
    case (round)
      2'd0:    round_word = cmd.key_a;
      2'd1:    round_word = cmd.key_b;
      default: round_word = cmd.key_c;
    endcase
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    push_valid = 1'b0;
    case (state)
      F_IDLE: begin
        req.ready = !status.clearing;
        if (req.valid && !status.clearing) begin
          state_next = F_HASH;
        end
      end
      F_HASH: begin
        if (round == HASH_LAST_ROUND) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      round <= 2'd0;
    end else begin
      state <= state_next;
      if (state == F_HASH) begin
        round <= (round == HASH_LAST_ROUND) ? 2'd0 : round + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && req.valid && req.ready) begin
      cmd.op          <= hrc_op_t'(req.operation);
      cmd.key_a       <= masked_a;
      cmd.key_b       <= req.key_b;
      cmd.key_c       <= req.key_c;
      cmd.store_value <= req.store_value;
      cmd.hash        <= HASH_BASIS ^ (masked_a >> HALF_SHIFT);
    end else if (state == F_HASH) begin
      cmd.hash <= hrc_mix(cmd.hash ^ round_word);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrc_cmd_queue.sv -----
// two entry command queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module hrc_cmd_queue import hrc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push_valid,
  input  wire hrc_cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output hrc_cmd_t      pop_cmd,
  input  wire logic     pop_ready
);

  hrc_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrc_back.sv -----
// back end: clears the index table, then runs stores and lookups in order
`timescale 1ns / 1ps
`default_nettype none

module hrc_back import hrc_pkg::*; #(
  parameter int unsigned INDEX_ENTRIES = 4096,
  parameter int unsigned DATA_ENTRIES  = 4096,
  parameter int unsigned TAG_BITS      = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pop_valid,
  input  wire hrc_cmd_t    pop_cmd,
  output logic             pop_ready,
  output hrc_back_status_t status,
  hrc_rsp_if.source        rsp
);

  localparam int unsigned IX_W   = $clog2(INDEX_ENTRIES);
  localparam int unsigned DX_W   = $clog2(DATA_ENTRIES);
  localparam int unsigned IDX_W  = 1 + TAG_BITS + DX_W;
  localparam int unsigned DATA_W = 256;

  typedef struct packed {
    logic                occupied;
    logic [TAG_BITS-1:0] tag;
    logic [DX_W-1:0]     slot;
  } idx_entry_t;

  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] value;
  } data_entry_t;

  hrc_back_state_t state, state_next;
  hrc_cmd_t        cmd;
  logic [IX_W-1:0] clear_addr;
  logic            res_hit;
  logic [63:0]     res_value;

  logic                cmd_ix_unused;
  logic [IX_W-1:0]     cmd_ix;
  logic [TAG_BITS-1:0] cmd_tag;
  logic [DX_W-1:0]     cmd_dx;

  logic        idx_we;
  logic [IX_W-1:0] idx_waddr;
  idx_entry_t  idx_wdata;
  logic        idx_re;
  idx_entry_t  idx_rdata;
  logic        dat_we;
  data_entry_t dat_wdata;
  logic        dat_re;
  data_entry_t dat_rdata;
  logic        tag_match;
  logic        key_match;
  logic        out_load;

  assign cmd_ix_unused = 1'b0;
  assign cmd_ix  = cmd.hash[IX_W-1:0];
  assign cmd_tag = cmd.hash[63 -: TAG_BITS];
  assign cmd_dx  = cmd.hash[DATA_SLOT_SHIFT +: DX_W];

  assign tag_match = idx_rdata.occupied && (idx_rdata.tag == cmd_tag);
  assign key_match = (dat_rdata.key_a == cmd.key_a) && (dat_rdata.key_b == cmd.key_b)
                     && (dat_rdata.key_c == cmd.key_c);

  assign dat_wdata = '{key_a: cmd.key_a, key_b: cmd.key_b, key_c: cmd.key_c,
                       value: cmd.store_value};

  assign status.clearing = (state == B_CLEAR) || cmd_ix_unused;

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    idx_we     = 1'b0;
    idx_waddr  = cmd_ix;
    idx_wdata  = '{occupied: 1'b1, tag: cmd_tag, slot: cmd_dx};
    idx_re     = 1'b0;
    dat_we     = 1'b0;
    dat_re     = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_CLEAR: begin
        idx_we    = 1'b1;
        idx_waddr = clear_addr;
        idx_wdata = '0;
        if (clear_addr == IX_W'(INDEX_ENTRIES - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cmd.op == OP_STORE) begin
          idx_we     = 1'b1;
          dat_we     = 1'b1;
          state_next = B_IDLE;
        end else begin
          idx_re     = 1'b1;
          state_next = B_IDX;
        end
      end
      B_IDX: begin
        if (tag_match) begin
          dat_re     = 1'b1;
          state_next = B_DATA;
        end else begin
          state_next = B_RESP;
        end
      end
      B_DATA: begin
        state_next = B_RESP;
      end
      B_RESP: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clear_addr <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clear_addr <= clear_addr + IX_W'(1);
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      cmd <= pop_cmd;
    end
    if (state == B_IDX && !tag_match) begin
      res_hit   <= 1'b0;
      res_value <= '0;
    end else if (state == B_DATA) begin
      res_hit   <= key_match;
      res_value <= key_match ? dat_rdata.value : 64'd0;
    end
    if (out_load) begin
      rsp.hit         <= res_hit;
      rsp.found_value <= res_value;
    end
  end

  hrc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (INDEX_ENTRIES)
  ) u_index_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .re    (idx_re),
    .raddr (cmd_ix),
    .rdata (idx_rdata)
  );

  hrc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DATA_ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (cmd_dx),
    .wdata (dat_wdata),
    .re    (dat_re),
    .raddr (idx_rdata.slot),
    .rdata (dat_rdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/hashed_result_cache_unit.sv -----
// top level of the hashed result cache
`timescale 1ns / 1ps
`default_nettype none

// Direct-mapped result cache keyed by three 64-bit words. Each request beat is
// a lookup or a store; a store gives no response beat, a lookup gives exactly
// one (hit and value on a hit, hit low and value zero on a miss). Bit 62 of
// key_a is ignored. The front end takes a beat and hashes the key in three
// FNV-1a style rounds (one multiply by the prime per cycle), then hands the
// command through a two-entry queue to the back end, which runs commands in
// order: a store writes the index and data tables in the same cycle, a lookup
// reads the index table and, on a tag match, then the data table (registered
// reads). The front end takes no new request beat until it has passed through
// its accept step, three hash rounds and the push into the queue. After
// reset the back end walks the index table clearing one entry a cycle, and no
// request beat is taken until that pass ends. INDEX_ENTRIES and DATA_ENTRIES
// are to be powers of two; the user must keep to this, as the block does not
// check it. The index slot is the low hash bits, the data slot the hash bits
// from 34 upward, and the tag the top TAG_BITS hash bits.

module hashed_result_cache_unit import hrc_pkg::*; #(
  parameter int unsigned INDEX_ENTRIES = 4096,
  parameter int unsigned DATA_ENTRIES  = 4096,
  parameter int unsigned TAG_BITS      = 20
) (
  input  wire logic clk,
  input  wire logic rst,
  hrc_req_if.sink   req,
  hrc_rsp_if.source rsp
);

  // front to queue
  logic             push_valid;
  logic             push_ready;
  hrc_cmd_t         push_cmd;
  // queue to back
  logic             pop_valid;
  logic             pop_ready;
  hrc_cmd_t         pop_cmd;
  // back end status, holds the front off during the clearing pass
  hrc_back_status_t status;

  hrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .status     (status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  hrc_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  hrc_back #(
    .INDEX_ENTRIES (INDEX_ENTRIES),
    .DATA_ENTRIES  (DATA_ENTRIES),
    .TAG_BITS      (TAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .status    (status),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
